// ===== rtl/alusf_pkg.sv =====
// Shared types and constants for the ALU with status flags.
package alusf_pkg;

   localparam logic [15:0] WORD_SIGN = 16'h8000;
   localparam logic [15:0] BYTE_SIGN = 16'h0080;
   localparam logic [15:0] HIGH_MASK = 16'hFF00;
   localparam logic [15:0] LOW_MASK  = 16'h00FF;
   localparam logic [15:0] WORD_MASK = 16'hFFFF;
   localparam logic [4:0]  BCD_LIMIT = 5'd10;
   localparam logic [3:0]  BCD_MAX   = 4'd9;

   typedef enum logic [4:0] {
      CMD_RRC   = 5'd0,
      CMD_SWPB  = 5'd1,
      CMD_RRA   = 5'd2,
      CMD_SXT   = 5'd3,
      CMD_MOV   = 5'd4,
      CMD_ADD   = 5'd5,
      CMD_ADDC  = 5'd6,
      CMD_SUBC  = 5'd7,
      CMD_SUB   = 5'd8,
      CMD_CMP   = 5'd9,
      CMD_DADD  = 5'd10,
      CMD_BIT   = 5'd11,
      CMD_BIC   = 5'd12,
      CMD_BIS   = 5'd13,
      CMD_XOR   = 5'd14,
      CMD_AND   = 5'd15,
      CMD_LDFLG = 5'd16
   } cmd_type;

   // Bit 0 carry, bit 1 zero, bit 2 negative, bit 3 overflow.
   typedef struct packed {
      logic overflow;
      logic negative;
      logic zero;
      logic carry;
   } flags_type;

   typedef struct packed {
      logic [4:0]  cmd;
      logic [15:0] src_value;
      logic [15:0] dst_value;
      logic        byte_mode;
   } req_type;

   typedef struct packed {
      logic [15:0] result_value;
      logic        write_back;
      flags_type   flags_out;
      logic [7:0]  jump_conditions;
      logic        digit_error;
   } rsp_type;

endpackage

// ===== rtl/alusf_if.sv =====
// Valid/ready channel interfaces for operation requests and results.
interface alusf_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  cmd;
   logic [15:0] src_value;
   logic [15:0] dst_value;
   logic        byte_mode;

   modport source (output valid, output cmd, output src_value, output dst_value,
                   output byte_mode, input ready);
   modport sink   (input valid, input cmd, input src_value, input dst_value,
                   input byte_mode, output ready);
endinterface

interface alusf_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] result_value;
   logic        write_back;
   logic [3:0]  flags_out;
   logic [7:0]  jump_conditions;
   logic        digit_error;

   modport source (output valid, output result_value, output write_back,
                   output flags_out, output jump_conditions, output digit_error,
                   input ready);
   modport sink   (input valid, input result_value, input write_back,
                   input flags_out, input jump_conditions, input digit_error,
                   output ready);
endinterface

// ===== rtl/alusf_core.sv =====
// Combinational datapath: result, write-back, new flags and jump conditions.
module alusf_core (
   input  alusf_pkg::req_type   op,
   input  alusf_pkg::flags_type flags_cur,
   output alusf_pkg::rsp_type   rsp,
   output alusf_pkg::flags_type flags_nxt
);

   logic [15:0] mask;
   logic [15:0] sign;
   logic [15:0] s;
   logic [15:0] d;
   logic        is_byte;
   logic        is_sub;
   logic        add_cin;
   logic [15:0] b_op;
   logic [16:0] full;
   logic [15:0] add_r;
   logic        add_c;
   logic        add_v;
   logic [4:0]  bcd_c;
   logic [4:0]  bcd_t;
   logic [15:0] bcd_raw;
   logic [15:0] bcd_r;
   logic        bcd_cout;
   logic        bcd_bad;
   logic [15:0] r;
   logic        wb;
   logic        derr;
   alusf_pkg::flags_type nf;
   alusf_pkg::cmd_type   cmd;

   assign cmd     = alusf_pkg::cmd_type'(op.cmd);
   assign is_byte = op.byte_mode;
   assign mask    = is_byte ? alusf_pkg::LOW_MASK : alusf_pkg::WORD_MASK;
   assign sign    = is_byte ? alusf_pkg::BYTE_SIGN : alusf_pkg::WORD_SIGN;
   assign s       = op.src_value & mask;
   assign d       = op.dst_value & mask;

   // shared adder for add, addc, sub, subc, cmp
   assign is_sub = (cmd == alusf_pkg::CMD_SUBC) || (cmd == alusf_pkg::CMD_SUB) ||
                   (cmd == alusf_pkg::CMD_CMP);
   assign add_cin = ((cmd == alusf_pkg::CMD_ADDC) || (cmd == alusf_pkg::CMD_SUBC)) ?
                    flags_cur.carry : ((cmd == alusf_pkg::CMD_SUB) ||
                                       (cmd == alusf_pkg::CMD_CMP));
   assign b_op  = is_sub ? (~s & mask) : s;
   assign full  = {1'b0, d} + {1'b0, b_op} + {16'b0, add_cin};
   assign add_r = full[15:0] & mask;
   assign add_c = is_byte ? full[8] : full[16];
   assign add_v = |(~(d ^ b_op) & (d ^ add_r) & sign);

   // packed BCD, one digit per step
   always_comb begin
      bcd_c    = '0;
      bcd_raw  = '0;
      bcd_bad  = 1'b0;
      bcd_t    = '0;
      bcd_c[0] = flags_cur.carry;
      for (int i = 0; i < 4; i++) begin
         if ((s[4*i +: 4] > alusf_pkg::BCD_MAX) || (d[4*i +: 4] > alusf_pkg::BCD_MAX)) begin
            bcd_bad = 1'b1;
         end
         bcd_t = {1'b0, s[4*i +: 4]} + {1'b0, d[4*i +: 4]} + {4'b0, bcd_c[i]};
         if (bcd_t >= alusf_pkg::BCD_LIMIT) begin
            bcd_t        = bcd_t - alusf_pkg::BCD_LIMIT;
            bcd_c[i + 1] = 1'b1;
         end else begin
            bcd_c[i + 1] = 1'b0;
         end
         bcd_raw[4*i +: 4] = bcd_t[3:0];
      end
   end

   assign bcd_r    = bcd_raw & mask;
   assign bcd_cout = is_byte ? bcd_c[2] : bcd_c[4];

   always_comb begin
      r    = '0;
      wb   = 1'b0;
      derr = 1'b0;
      nf   = flags_cur;
      case (cmd)
         alusf_pkg::CMD_RRC: begin
            r           = (d >> 1) | (flags_cur.carry ? sign : 16'h0000);
            nf.carry    = d[0];
            nf.zero     = (r == 16'h0000);
            nf.negative = |(r & sign);
            nf.overflow = 1'b0;
            wb          = 1'b1;
         end
         alusf_pkg::CMD_SWPB: begin
            r  = {op.dst_value[7:0], op.dst_value[15:8]};
            wb = 1'b1;
         end
         alusf_pkg::CMD_RRA: begin
            r           = (d >> 1) | (d & sign);
            nf.carry    = d[0];
            nf.zero     = (r == 16'h0000);
            nf.negative = |(r & sign);
            nf.overflow = 1'b0;
            wb          = 1'b1;
         end
         alusf_pkg::CMD_SXT: begin
            r           = {{8{op.dst_value[7]}}, op.dst_value[7:0]};
            nf.zero     = (r == 16'h0000);
            nf.negative = r[15];
            nf.carry    = (r != 16'h0000);
            nf.overflow = 1'b0;
            wb          = 1'b1;
         end
         alusf_pkg::CMD_MOV: begin
            r  = s;
            wb = 1'b1;
         end
         alusf_pkg::CMD_ADD, alusf_pkg::CMD_ADDC, alusf_pkg::CMD_SUBC,
         alusf_pkg::CMD_SUB, alusf_pkg::CMD_CMP: begin
            r           = add_r;
            nf.carry    = add_c;
            nf.zero     = (add_r == 16'h0000);
            nf.negative = |(add_r & sign);
            nf.overflow = add_v;
            wb          = (cmd != alusf_pkg::CMD_CMP);
         end
         alusf_pkg::CMD_DADD: begin
            if (bcd_bad) begin
               derr = 1'b1;
            end else begin
               r           = bcd_r;
               nf.carry    = bcd_cout;
               nf.zero     = (bcd_r == 16'h0000);
               nf.negative = |(bcd_r & sign);
               nf.overflow = 1'b0;
               wb          = 1'b1;
            end
         end
         alusf_pkg::CMD_BIT, alusf_pkg::CMD_AND: begin
            r           = s & d;
            nf.zero     = (r == 16'h0000);
            nf.negative = |(r & sign);
            nf.carry    = (r != 16'h0000);
            nf.overflow = 1'b0;
            wb          = (cmd == alusf_pkg::CMD_AND);
         end
         alusf_pkg::CMD_BIC: begin
            r  = d & ~s & mask;
            wb = 1'b1;
         end
         alusf_pkg::CMD_BIS: begin
            r  = s | d;
            wb = 1'b1;
         end
         alusf_pkg::CMD_XOR: begin
            r           = s ^ d;
            nf.zero     = (r == 16'h0000);
            nf.negative = |(r & sign);
            nf.carry    = (r != 16'h0000);
            nf.overflow = (|(s & sign)) && (|(d & sign));
            wb          = 1'b1;
         end
         alusf_pkg::CMD_LDFLG: begin
            nf = alusf_pkg::flags_type'(op.src_value[3:0]);
         end
         default: begin
            r = '0;
         end
      endcase
   end

   assign flags_nxt            = nf;
   assign rsp.result_value     = r;
   assign rsp.write_back       = wb;
   assign rsp.flags_out        = nf;
   assign rsp.digit_error      = derr;
   assign rsp.jump_conditions  = {1'b1,
                                  nf.negative != nf.overflow,
                                  nf.negative == nf.overflow,
                                  nf.negative,
                                  nf.carry,
                                  ~nf.carry,
                                  nf.zero,
                                  ~nf.zero};

endmodule

// ===== rtl/alu_with_status_flags.sv =====
// 16-bit ALU top with kept status flags; one op per cycle unless stalled.
//
// Usage:
//   req_bus carries one operation per transaction: cmd, src_value,
//   dst_value and byte_mode. rsp_bus returns one transaction per operation
//   with result_value, write_back, flags_out, jump_conditions and
//   digit_error, in the order the operations were taken.
//   Each transaction passes through two register stages: the operand
//   register, then the result register. Throughput: one transaction per
//   cycle unless rsp_bus stalls. The carry, zero, negative and overflow
//   flags live in one register that the datapath reads and updates as
//   each operation moves from the operand register into the result
//   register, so consecutive operations chain through the flags.
//   Reset (synchronous, active high) empties both stages and clears all
//   four flags.
//   When rsp_bus stalls, the result register holds; the operand register
//   can still take one more transaction, then req_bus.ready drops until
//   the result is taken.
module alu_with_status_flags (
   input  logic             clock,
   input  logic             reset,
   alusf_req_if.sink        req_bus,
   alusf_rsp_if.source      rsp_bus
);

   logic                 op_valid_ff;
   alusf_pkg::req_type   op_ff;
   logic                 out_valid_ff;
   alusf_pkg::rsp_type   out_ff;
   alusf_pkg::flags_type flags_ff;

   logic                 op_valid_in;
   logic                 out_valid_in;
   alusf_pkg::rsp_type   core_rsp;
   alusf_pkg::flags_type flags_in;
   logic                 op_advance;
   logic                 req_take;
   alusf_pkg::req_type   req_data;

   alusf_core u_core (
      .op        (op_ff),
      .flags_cur (flags_ff),
      .rsp       (core_rsp),
      .flags_nxt (flags_in)
   );

   assign op_advance     = op_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready  = !op_valid_ff || op_advance;
   assign req_take       = req_bus.valid && req_bus.ready;
   assign op_valid_in    = req_take || (op_valid_ff && !op_advance);
   assign out_valid_in   = op_advance || (out_valid_ff && !rsp_bus.ready);

   assign req_data.cmd       = req_bus.cmd;
   assign req_data.src_value = req_bus.src_value;
   assign req_data.dst_value = req_bus.dst_value;
   assign req_data.byte_mode = req_bus.byte_mode;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         op_valid_ff  <= op_valid_in;
         out_valid_ff <= out_valid_in;
         if (op_advance) begin
            flags_ff <= flags_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff <= req_data;
      end
      if (op_advance) begin
         out_ff <= core_rsp;
      end
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.result_value    = out_ff.result_value;
   assign rsp_bus.write_back      = out_ff.write_back;
   assign rsp_bus.flags_out       = out_ff.flags_out;
   assign rsp_bus.jump_conditions = out_ff.jump_conditions;
   assign rsp_bus.digit_error     = out_ff.digit_error;

   // flags move only with an operation
   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      !op_advance |=> $stable(flags_ff))
      else $error("flags changed without an operation");

   // reported flags match the kept flags
   a_flags_match: assert property (@(posedge clock) disable iff (reset)
      op_advance |=> (rsp_bus.flags_out == flags_ff))
      else $error("reported flags differ from kept flags");

   // a rejected decimal add writes nothing
   a_digit_error: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.digit_error) |-> (!out_ff.write_back &&
                                                out_ff.result_value == 16'h0000))
      else $error("digit error with write-back");

   // result register never overwritten while stalled
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_bus.ready) |-> !op_advance)
      else $error("result overwritten while stalled");

endmodule
